// ===== design/eca_pkg.sv =====
package eca_pkg;

   localparam int MUL_W = 32;
   localparam int PROD_W = 2 * MUL_W;

   localparam int TIME_W = 32;
   localparam int GAP_W = 16;
   localparam int VOLT_W = 16;
   localparam int CUR_W = 14;
   localparam int ENERGY_W = 64;
   localparam int CHARGE_W = 48;
   localparam int SEC_W = 32;

   localparam int Q_W = CUR_W + GAP_W;
   localparam int E_W = VOLT_W + Q_W;

   // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT for every 32-bit x
   localparam logic [MUL_W-1:0] RECIP_1000 = 32'd274877907;
   localparam int RECIP_SHIFT = 38;

   localparam logic [15:0] MAX_GAP_RESET = 16'd1000;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_Q    = 5'b00010,
      ST_E    = 5'b00100,
      ST_SEC  = 5'b01000,
      ST_UPD  = 5'b10000
   } state_type;

endpackage

// ===== design/eca_mul.sv =====
module eca_mul (
   input  logic                          clock,
   input  logic [eca_pkg::MUL_W-1:0]     op_a,
   input  logic [eca_pkg::MUL_W-1:0]     op_b,
   output logic [eca_pkg::PROD_W-1:0]    prod_ff
);
   import eca_pkg::*;

   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/energy_charge_accumulator.sv =====
// Energy and charge accumulator for power-meter samples. Each transaction carries a
// millisecond timestamp, the output-enabled flag, bus voltage (mV) and current (mA).
// While enabled, the first sample opens a session; later samples whose wrapping gap
// is nonzero and below max_gap_ms add V*I*gap (nJ) and I*gap (uC) to saturating
// totals. A disabled sample closes the session and banks its whole seconds. One
// result transaction per sample. The result is registered at the end of four
// sequencer steps around a single shared 32x32 multiplier, which is used three
// times (I*gap, V*q, and elapsed time times the reciprocal of 1000). The last
// step waits while an earlier result is still stalled. The next sample is
// accepted in the idle cycle that follows. The result register frees the input
// side, so the next sample is taken while a result waits. max_gap_ms resets to
// 1000.
module energy_charge_accumulator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [15:0]                     csr_wr_data,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [eca_pkg::TIME_W-1:0]      req_timestamp_ms,
   input  logic                            req_output_enabled,
   input  logic [eca_pkg::VOLT_W-1:0]      req_voltage_mv,
   input  logic [eca_pkg::CUR_W-1:0]       req_current_ma,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [eca_pkg::ENERGY_W-1:0]    rsp_energy_nj,
   output logic [eca_pkg::CHARGE_W-1:0]    rsp_charge_uc,
   output logic [eca_pkg::SEC_W-1:0]       rsp_output_seconds,
   output logic                            rsp_session_open
);
   import eca_pkg::*;

   state_type state_ff, state_in;

   logic [15:0]         max_gap_ff;
   logic [TIME_W-1:0]   t_ff;
   logic                en_ff;
   logic [VOLT_W-1:0]   v_ff;
   logic [CUR_W-1:0]    i_ff;
   logic [TIME_W-1:0]   gap_ff;
   logic [Q_W-1:0]      q_ff;
   logic [E_W-1:0]      e_ff;

   logic                active_ff, active_in;
   logic [TIME_W-1:0]   start_ff, start_in;
   logic [TIME_W-1:0]   last_ff, last_in;
   logic [ENERGY_W-1:0] energy_ff, energy_in;
   logic [CHARGE_W-1:0] charge_ff, charge_in;
   logic [SEC_W-1:0]    past_ff, past_in;

   logic                rsp_valid_ff;
   logic [ENERGY_W-1:0] rsp_energy_ff;
   logic [CHARGE_W-1:0] rsp_charge_ff;
   logic [SEC_W-1:0]    rsp_seconds_ff;
   logic                rsp_open_ff;

   logic [MUL_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0]   prod_ff;

   logic                accept;
   logic                out_free;
   logic [TIME_W-1:0]   gap_now;
   logic [TIME_W-1:0]   elapsed;
   logic [SEC_W-1:0]    secs;
   logic [SEC_W:0]      sec_sum;
   logic [SEC_W-1:0]    sec_sat;
   logic                gap_ok;
   logic [ENERGY_W:0]   energy_sum;
   logic [CHARGE_W:0]   charge_sum;

   eca_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign gap_now = t_ff - last_ff;
   assign elapsed = active_ff ? (t_ff - start_ff) : '0;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_Q: begin
            mul_a = MUL_W'(gap_now[GAP_W-1:0]);
            mul_b = MUL_W'(i_ff);
         end
         ST_E: begin
            mul_a = MUL_W'(prod_ff[Q_W-1:0]);
            mul_b = MUL_W'(v_ff);
         end
         ST_SEC, ST_UPD: begin
            mul_a = elapsed;
            mul_b = RECIP_1000;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      secs       = SEC_W'(prod_ff[PROD_W-1:RECIP_SHIFT]);
      sec_sum    = {1'b0, past_ff} + {1'b0, secs};
      sec_sat    = sec_sum[SEC_W] ? '1 : sec_sum[SEC_W-1:0];
      gap_ok     = active_ff && (gap_ff != '0) && (gap_ff < TIME_W'(max_gap_ff));
      energy_sum = {1'b0, energy_ff} + (ENERGY_W + 1)'(e_ff);
      charge_sum = {1'b0, charge_ff} + (CHARGE_W + 1)'(q_ff);

      active_in = active_ff;
      start_in  = start_ff;
      last_in   = last_ff;
      energy_in = energy_ff;
      charge_in = charge_ff;
      past_in   = past_ff;

      if (en_ff) begin
         if (!active_ff) begin
            active_in = 1'b1;
            start_in  = t_ff;
         end else if (gap_ok) begin
            energy_in = energy_sum[ENERGY_W] ? '1 : energy_sum[ENERGY_W-1:0];
            charge_in = charge_sum[CHARGE_W] ? '1 : charge_sum[CHARGE_W-1:0];
         end
         last_in = t_ff;
      end else begin
         if (active_ff) begin
            past_in   = sec_sat;
            active_in = 1'b0;
            start_in  = '0;
         end
         last_in = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_Q;
         ST_Q:    state_in = ST_E;
         ST_E:    state_in = ST_SEC;
         ST_SEC:  state_in = ST_UPD;
         ST_UPD:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_gap_ff   <= MAX_GAP_RESET;
         active_ff    <= 1'b0;
         start_ff     <= '0;
         last_ff      <= '0;
         energy_ff    <= '0;
         charge_ff    <= '0;
         past_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            max_gap_ff <= csr_wr_data;
         end
         if (state_ff == ST_UPD && out_free) begin
            active_ff    <= active_in;
            start_ff     <= start_in;
            last_ff      <= last_in;
            energy_ff    <= energy_in;
            charge_ff    <= charge_in;
            past_ff      <= past_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff  <= req_timestamp_ms;
         en_ff <= req_output_enabled;
         v_ff  <= req_voltage_mv;
         i_ff  <= req_current_ma;
      end
      if (state_ff == ST_Q) begin
         gap_ff <= gap_now;
      end
      if (state_ff == ST_E) begin
         q_ff <= prod_ff[Q_W-1:0];
      end
      if (state_ff == ST_SEC) begin
         e_ff <= prod_ff[E_W-1:0];
      end
      if (state_ff == ST_UPD && out_free) begin
         rsp_energy_ff  <= energy_in;
         rsp_charge_ff  <= charge_in;
         rsp_seconds_ff <= active_ff ? sec_sat : past_ff;
         rsp_open_ff    <= active_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_energy_nj      = rsp_energy_ff;
   assign rsp_charge_uc      = rsp_charge_ff;
   assign rsp_output_seconds = rsp_seconds_ff;
   assign rsp_session_open   = rsp_open_ff;

endmodule

// ===== sim/energy_charge_accumulator_tb.sv =====
module energy_charge_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import eca_pkg::*;

   localparam int MS_PER_SEC = 1000;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int RANDOM_PHASES = 8;
   localparam int SAT_SESSIONS = 130;
   localparam int MAX_REPORTS = 10;

   typedef struct {
      logic [TIME_W-1:0] ts;
      logic              enabled;
      logic [VOLT_W-1:0] volt;
      logic [CUR_W-1:0]  amps;
      bit                drain;
   } sample_type;

   typedef struct packed {
      logic [ENERGY_W-1:0] energy;
      logic [CHARGE_W-1:0] charge;
      logic [SEC_W-1:0]    seconds;
      logic                sess_open;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              csr_wr_en = 1'b0;
   logic [15:0]       csr_wr_data = '0;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [TIME_W-1:0] req_timestamp_ms = '0;
   logic              req_output_enabled = 1'b0;
   logic [VOLT_W-1:0] req_voltage_mv = '0;
   logic [CUR_W-1:0]  req_current_ma = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [ENERGY_W-1:0] rsp_energy_nj;
   logic [CHARGE_W-1:0] rsp_charge_uc;
   logic [SEC_W-1:0]    rsp_output_seconds;
   logic                rsp_session_open;

   energy_charge_accumulator u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_timestamp_ms   (req_timestamp_ms),
      .req_output_enabled (req_output_enabled),
      .req_voltage_mv     (req_voltage_mv),
      .req_current_ma     (req_current_ma),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_energy_nj      (rsp_energy_nj),
      .rsp_charge_uc      (rsp_charge_uc),
      .rsp_output_seconds (rsp_output_seconds),
      .rsp_session_open   (rsp_session_open)
   );

   initial forever #5 clock = ~clock;

   sample_type  pending_q[$];
   reading_type expected_readings[$];
   int       sent_count;
   int       got_count;
   int       fail_count = 0;
   int       quiet_cycles;
   bit       no_idle = 1'b0;

   // meter state mirror
   logic [GAP_W-1:0]    gap_limit;
   logic                sess_on;
   logic [TIME_W-1:0]   sess_t0;
   logic [TIME_W-1:0]   prev_t;
   logic [ENERGY_W-1:0] energy_acc;
   logic [CHARGE_W-1:0] charge_acc;
   logic [SEC_W-1:0]    banked_s;

   function automatic int pace();
      return no_idle ? 0 : $urandom_range(0, 10);
   endfunction

   function automatic reading_type meter_step(input sample_type s);
      logic [TIME_W-1:0]   gap;
      logic [TIME_W-1:0]   span;
      logic [Q_W-1:0]      q;
      logic [E_W-1:0]      e;
      logic [ENERGY_W:0]   esum;
      logic [CHARGE_W:0]   csum;
      logic [SEC_W:0]      ssum;
      logic [SEC_W-1:0]    total;
      reading_type         r;
      if (s.enabled) begin
         if (!sess_on) begin
            sess_on = 1'b1;
            sess_t0 = s.ts;
            prev_t = s.ts;
         end else begin
            gap = s.ts - prev_t;
            if (gap != 0 && gap < {16'd0, gap_limit}) begin
               q = Q_W'(s.amps) * Q_W'(gap[GAP_W-1:0]);
               e = E_W'(s.volt) * E_W'(q);
               esum = {1'b0, energy_acc} + (ENERGY_W + 1)'(e);
               energy_acc = esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];
               csum = {1'b0, charge_acc} + (CHARGE_W + 1)'(q);
               charge_acc = csum[CHARGE_W] ? '1 : csum[CHARGE_W-1:0];
            end
            prev_t = s.ts;
         end
      end else begin
         if (sess_on) begin
            span = s.ts - sess_t0;
            span = span / TIME_W'(MS_PER_SEC);
            ssum = {1'b0, banked_s} + {1'b0, span};
            banked_s = ssum[SEC_W] ? '1 : ssum[SEC_W-1:0];
            sess_on = 1'b0;
            sess_t0 = '0;
         end
         prev_t = '0;
      end
      total = banked_s;
      if (sess_on) begin
         span = s.ts - sess_t0;
         span = span / TIME_W'(MS_PER_SEC);
         ssum = {1'b0, banked_s} + {1'b0, span};
         total = ssum[SEC_W] ? '1 : ssum[SEC_W-1:0];
      end
      r.energy = energy_acc;
      r.charge = charge_acc;
      r.seconds = total;
      r.sess_open = sess_on;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         gap_limit <= MAX_GAP_RESET;
      end else if (csr_wr_en) begin
         gap_limit <= csr_wr_data;
      end
   end

   // driver
   int         drv_gap;
   sample_type drv_item;
   bit         took;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap = 0;
         sent_count <= 0;
         sess_on = 1'b0;
         sess_t0 = '0;
         prev_t = '0;
         energy_acc = '0;
         charge_acc = '0;
         banked_s = '0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            drv_item.ts = req_timestamp_ms;
            drv_item.enabled = req_output_enabled;
            drv_item.volt = req_voltage_mv;
            drv_item.amps = req_current_ma;
            expected_readings.push_back(meter_step(drv_item));
            sent_count <= sent_count + 1;
            drv_gap = pace();
         end
         if (took || !req_valid) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain && (took || got_count != sent_count))) begin
               drv_item = pending_q.pop_front();
               req_valid <= 1'b1;
               req_timestamp_ms <= drv_item.ts;
               req_output_enabled <= drv_item.enabled;
               req_voltage_mv <= drv_item.volt;
               req_current_ma <= drv_item.amps;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   int          stall_left;
   reading_type got;
   reading_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         got_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_count <= got_count + 1;
            got.energy = rsp_energy_nj;
            got.charge = rsp_charge_uc;
            got.seconds = rsp_output_seconds;
            got.sess_open = rsp_session_open;
            if (got_count >= sent_count) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display({"reading %0d: none expected, got energy %0d charge %0d",
                            " seconds %0d open %0b"},
                           got_count, got.energy, got.charge, got.seconds, got.sess_open);
            end else begin
               want = expected_readings.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS) begin
                     $display("reading %0d: expected energy %0d charge %0d seconds %0d %s%0b",
                              got_count, want.energy, want.charge, want.seconds,
                              "open ", want.sess_open);
                     $display("reading %0d: actual   energy %0d charge %0d seconds %0d %s%0b",
                              got_count, got.energy, got.charge, got.seconds,
                              "open ", got.sess_open);
                  end
               end
            end
            stall_left = pace();
            rsp_stall <= (stall_left != 0);
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= (stall_left != 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic void queue_sample(input logic [TIME_W-1:0] ts, input logic en,
                                        input logic [VOLT_W-1:0] v, input logic [CUR_W-1:0] a,
                                        input bit drain);
      sample_type s;
      s.ts = ts;
      s.enabled = en;
      s.volt = v;
      s.amps = a;
      s.drain = drain;
      pending_q.push_back(s);
   endfunction

   function automatic logic [VOLT_W-1:0] draw_volt();
      return ($urandom_range(0, 3) == 0) ? '1 : VOLT_W'($urandom);
   endfunction

   function automatic logic [CUR_W-1:0] draw_amps();
      return ($urandom_range(0, 3) == 0) ? '1 : CUR_W'($urandom);
   endfunction

   function automatic logic [TIME_W-1:0] draw_gap(input logic [GAP_W-1:0] lim);
      case ($urandom_range(0, 11))
         0: return '0;
         1: return TIME_W'(lim);
         2: return TIME_W'(lim) - 1;
         3: return $urandom;
         4: return TIME_W'(lim) + $urandom_range(1, 100);
         default: return $urandom_range(1, (lim > 1) ? lim - 1 : 1);
      endcase
   endfunction

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_q.size() != 0 || req_valid || got_count != sent_count);
   endtask

   task automatic settle_and_set_gap(input logic [GAP_W-1:0] val);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_random_phase(input int count, input logic [GAP_W-1:0] lim);
      int left;
      int n;
      int k;
      logic [TIME_W-1:0] t;
      logic [TIME_W-1:0] t0;
      left = count;
      while (left > 0) begin
         case ($urandom_range(0, 9))
            0: begin
               queue_sample($urandom, 1'($urandom_range(0, 1)), VOLT_W'($urandom),
                            CUR_W'($urandom), $urandom_range(0, 39) == 0);
               left--;
            end
            1: begin
               queue_sample($urandom, 1'b0, draw_volt(), draw_amps(), 1'b0);
               left--;
            end
            default: begin
               t = $urandom;
               t0 = t;
               queue_sample(t, 1'b1, draw_volt(), draw_amps(), $urandom_range(0, 39) == 0);
               n = $urandom_range(1, 16);
               for (k = 0; k < n; k++) begin
                  t = t + draw_gap(lim);
                  queue_sample(t, 1'b1, draw_volt(), draw_amps(),
                               $urandom_range(0, 39) == 0);
               end
               left -= n + 1;
               // some sessions are left open on purpose
               if ($urandom_range(0, 7) != 0) begin
                  case ($urandom_range(0, 3))
                     0: t = $urandom;
                     1: t = t0 - 1 - $urandom_range(0, 5000);
                     default: t = t + $urandom_range(0, 20000);
                  endcase
                  queue_sample(t, 1'b0, draw_volt(), draw_amps(), 1'b0);
                  left--;
               end
            end
         endcase
      end
   endtask

   initial begin
      int k;
      logic [GAP_W-1:0]  lim;
      logic [TIME_W-1:0] t;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      queue_sample(32'd5, 1'b0, '1, '1, 1'b0);
      queue_sample(32'd100, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd100, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd101, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd1100, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd2100, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd2000, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd2500, 1'b1, '0, '0, 1'b0);
      queue_sample(32'd7500, 1'b0, '1, '1, 1'b1);
      queue_sample(32'd0, 1'b0, '0, '0, 1'b0);
      queue_sample(32'hFFFF_FF00, 1'b1, 16'd1, 14'd1, 1'b0);
      queue_sample(32'h0000_0010, 1'b1, '1, '1, 1'b0);
      queue_sample(32'hFFFF_FEFF, 1'b1, '1, '1, 1'b0);
      queue_sample(32'hFFFF_FEFF, 1'b0, '1, '1, 1'b0);

      settle_and_set_gap(16'd0);
      queue_sample(32'd10, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd11, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd20, 1'b0, '1, '1, 1'b0);

      settle_and_set_gap(16'hFFFF);
      queue_sample(32'd0, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd65534, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd131069, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd200000, 1'b0, '1, '1, 1'b0);

      settle_and_set_gap(16'd1);
      queue_sample(32'd50, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd50, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd51, 1'b1, '1, '1, 1'b0);
      queue_sample(32'd52, 1'b0, '1, '1, 1'b0);

      for (k = 0; k < RANDOM_PHASES; k++) begin
         lim = GAP_W'($urandom_range(1, 65535));
         case (k)
            0: lim = MAX_GAP_RESET;
            1: lim = 16'd1;
            2: lim = 16'hFFFF;
            3: lim = 16'd0;
            5: lim = 16'd2;
            default: ;
         endcase
         settle_and_set_gap(lim);
         no_idle = ($urandom_range(0, 3) == 0);
         queue_random_phase(RANDOM_ITEMS / RANDOM_PHASES, lim);
      end

      // long sessions closed just before they opened build a large seconds count
      settle_and_set_gap(MAX_GAP_RESET);
      no_idle = 1'b0;
      for (k = 0; k < SAT_SESSIONS; k++) begin
         t = $urandom;
         queue_sample(t, 1'b1, draw_volt(), draw_amps(), 1'b0);
         queue_sample(t - 1, 1'b1, draw_volt(), draw_amps(), 1'b0);
         queue_sample(t - 1 - $urandom_range(0, 999), 1'b0, draw_volt(), draw_amps(), 1'b0);
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (expected_readings.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
